// ----- rtl/ede_pkg.sv -----
// Shared constants and types for the Euclidean distance engine.
// No dependencies; imported by every ede_* module and the top level.
`default_nettype none

package ede_pkg;

    // Default widths for the top-level parameters
    localparam int DEFAULT_FEATURE_WIDTH = 16;
    localparam int DEFAULT_SUM_WIDTH     = 48;

    // Width of the distance result field, Q.8
    localparam int DIST_WIDTH = 24;

    // Entries in the queue between accumulator and square root unit
    localparam int QUEUE_DEPTH = 2;

    // Square root sequencer states
    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RUN,
        SQ_HOLD
    } sqrt_state_t;

endpackage

`default_nettype wire

// ----- rtl/euclidean_distance_engine.sv -----
// Top level of the Euclidean distance engine.
// Uses ede_pkg, ede_front, ede_queue and ede_sqrt.
`default_nettype none

// Streaming L2 distance between two vectors of signed Q7.8 features. Each
// input transfer carries one element pair; the squared difference (Q.16) is
// added to a running sum that saturates at 2^SUM_WIDTH - 1. The transfer
// with last_element set closes the vector: its pair is included, and one
// output transfer later carries floor(sqrt(sum)) as an unsigned Q.8
// distance (masked to 24 bits) plus a flag set if the sum saturated. Every
// other input transfer produces no output. The accumulator takes one pair
// per cycle unless stalled; a pair passes through its difference, multiply
// and add stages. The root unit resolves one result bit per cycle and
// works on one vector at a time. Two finished sums can wait between the
// two parts, so input only stalls when a vector closes into a full queue:
// when vectors are on average shorter than the root unit's time per
// vector, or when the output side holds back its transfers.
module euclidean_distance_engine #(
    parameter int FEATURE_WIDTH = ede_pkg::DEFAULT_FEATURE_WIDTH,
    parameter int SUM_WIDTH     = ede_pkg::DEFAULT_SUM_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [FEATURE_WIDTH-1:0]      feature_a,
    input  wire logic [FEATURE_WIDTH-1:0]      feature_b,
    input  wire logic                          last_element,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ede_pkg::DIST_WIDTH-1:0]     distance,
    output logic                               saturated
);

    import ede_pkg::*;

    // Queue traffic between accumulator and root unit
    logic                 q_full;
    logic                 q_empty;
    logic                 q_push;
    logic                 q_pop;
    logic [SUM_WIDTH-1:0] push_sum;
    logic                 push_ovf;
    logic [SUM_WIDTH-1:0] head_sum;
    logic                 head_ovf;

    ede_front #(
        .FEATURE_WIDTH (FEATURE_WIDTH),
        .SUM_WIDTH     (SUM_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .feature_a    (feature_a),
        .feature_b    (feature_b),
        .last_element (last_element),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_sum        (push_sum),
        .q_ovf        (push_ovf)
    );

    ede_queue #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_sum (push_sum),
        .push_ovf (push_ovf),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_sum (head_sum),
        .head_ovf (head_ovf)
    );

    // Root unit owns the output register
    ede_sqrt #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_sum     (head_sum),
        .q_ovf     (head_ovf),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance),
        .saturated (saturated)
    );

endmodule

`default_nettype wire

// ----- rtl/ede_front.sv -----
// Front end: difference, square and saturating sum of squares.
// Uses ede_pkg; pushes one finished sum per vector into ede_queue.
`default_nettype none

module ede_front #(
    parameter int FEATURE_WIDTH = ede_pkg::DEFAULT_FEATURE_WIDTH,
    parameter int SUM_WIDTH     = ede_pkg::DEFAULT_SUM_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [FEATURE_WIDTH-1:0] feature_a,
    input  wire logic [FEATURE_WIDTH-1:0] feature_b,
    input  wire logic                     last_element,
    input  wire logic                     q_full,
    output logic                          q_push,
    output logic [SUM_WIDTH-1:0]          q_sum,
    output logic                          q_ovf
);

    import ede_pkg::*;

    localparam int SQ_W  = 2 * FEATURE_WIDTH;
    localparam int ACC_W = ((SUM_WIDTH > SQ_W) ? SUM_WIDTH : SQ_W) + 1;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

    logic                     adv;
    logic [FEATURE_WIDTH:0]   diff_s;
    logic [FEATURE_WIDTH:0]   diff_neg;
    logic [FEATURE_WIDTH-1:0] diff_mag;

    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic [FEATURE_WIDTH-1:0] s1_diff_reg;
    logic                     s2_valid_reg;
    logic                     s2_last_reg;
    logic [SQ_W-1:0]          s2_sq_reg;

    logic [SUM_WIDTH-1:0]     sum_reg;
    logic [SUM_WIDTH-1:0]     sum_next;
    logic                     ovf_reg;
    logic                     ovf_next;
    logic [ACC_W-1:0]         total;
    logic                     over;
    logic [SUM_WIDTH-1:0]     sum_upd;
    logic                     ovf_upd;

    // Pipeline moves as one; only a last item facing a full queue holds it
    assign adv      = !(s2_valid_reg && s2_last_reg && q_full);
    assign in_ready = adv;

    // |a - b| in one extra bit, magnitude fits FEATURE_WIDTH bits
    assign diff_s   = {feature_a[FEATURE_WIDTH-1], feature_a}
                    - {feature_b[FEATURE_WIDTH-1], feature_b};
    assign diff_neg = -diff_s;
    assign diff_mag = diff_s[FEATURE_WIDTH] ? diff_neg[FEATURE_WIDTH-1:0]
                                            : diff_s[FEATURE_WIDTH-1:0];

    // Saturating add
    assign total   = ACC_W'(sum_reg) + ACC_W'(s2_sq_reg);
    assign over    = total > ACC_W'(SUM_MAX);
    assign sum_upd = over ? SUM_MAX : total[SUM_WIDTH-1:0];
    assign ovf_upd = ovf_reg || over;

    assign q_push = adv && s2_valid_reg && s2_last_reg;
    assign q_sum  = sum_upd;
    assign q_ovf  = ovf_upd;

    always_comb
    begin
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        if (adv && s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                sum_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                sum_next = sum_upd;
                ovf_next = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
            if (adv)
            begin
                s1_valid_reg <= in_valid;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_diff_reg <= diff_mag;
            s1_last_reg <= last_element;
            s2_sq_reg   <= s1_diff_reg * s1_diff_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

`ifndef ASSERT_OFF
    // Once the sum has saturated it stays pinned at its maximum until cleared
    a_ovf_pins_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (sum_reg == SUM_MAX))
        else $error("overflow flag set with sum below maximum");
`endif

endmodule

`default_nettype wire

// ----- rtl/ede_queue.sv -----
// Short queue of finished sums between the accumulator and the root unit.
// Uses ede_pkg for its depth.
`default_nettype none

module ede_queue #(
    parameter int SUM_WIDTH = ede_pkg::DEFAULT_SUM_WIDTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [SUM_WIDTH-1:0] push_sum,
    input  wire logic                 push_ovf,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      empty,
    output logic [SUM_WIDTH-1:0]      head_sum,
    output logic                      head_ovf
);

    import ede_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [SUM_WIDTH-1:0] sum_mem_reg [QUEUE_DEPTH];
    logic                 ovf_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_sum = sum_mem_reg[rd_ptr_reg];
    assign head_ovf = ovf_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            sum_mem_reg[wr_ptr_reg] <= push_sum;
            ovf_mem_reg[wr_ptr_reg] <= push_ovf;
        end
    end

`ifndef ASSERT_OFF
    // Upstream must never offer a sum that would be dropped
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    // Root unit only takes a sum that is present
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count past depth");
`endif

endmodule

`default_nettype wire

// ----- rtl/ede_sqrt.sv -----
// Back end: bit-serial floor square root, one root bit per cycle,
// with the result register on the output channel. Uses ede_pkg.
`default_nettype none

module ede_sqrt #(
    parameter int SUM_WIDTH = ede_pkg::DEFAULT_SUM_WIDTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_empty,
    input  wire logic [SUM_WIDTH-1:0] q_sum,
    input  wire logic                 q_ovf,
    output logic                      q_pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ede_pkg::DIST_WIDTH-1:0] distance,
    output logic                      saturated
);

    import ede_pkg::*;

    localparam int ROOT_W = (SUM_WIDTH + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEP_W = $clog2(ROOT_W);

    sqrt_state_t state_reg;
    sqrt_state_t state_next;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [STEP_W-1:0] step_reg;
    logic              ovf_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DIST_WIDTH-1:0] dist_reg;
    logic              sat_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic [REM_W-1:0]  rem_new;
    logic [ROOT_W-1:0] root_new;
    logic [ROOT_W+DIST_WIDTH-1:0] root_wide;
    logic              last_step;
    logic              load_out;
    logic              start;

    // One restoring step: bring down two radicand bits, try (4r + 1)
    assign rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign ge        = (rem_sh >= trial);
    assign rem_new   = ge ? (rem_sh - trial) : rem_sh;
    assign root_new  = {root_reg[ROOT_W-2:0], ge};
    assign last_step = (step_reg == STEP_W'(ROOT_W - 1));
    assign root_wide = {{DIST_WIDTH{1'b0}}, root_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE:
                if (!q_empty)
                    state_next = SQ_RUN;
            SQ_RUN:
                if (last_step)
                    state_next = SQ_HOLD;
            SQ_HOLD:
                if (!out_valid_reg || out_ready)
                    state_next = SQ_IDLE;
            default:
                state_next = SQ_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        start    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            SQ_IDLE: start    = !q_empty;
            SQ_RUN:  ;
            SQ_HOLD: load_out = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    assign q_pop = start;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= RAD_W'(q_sum);
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
            ovf_reg  <= q_ovf;
        end
        else if (state_reg == SQ_RUN)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_new;
            root_reg <= root_new;
            step_reg <= step_reg + 1'b1;
        end
        if (load_out)
        begin
            dist_reg <= root_wide[DIST_WIDTH-1:0];
            sat_reg  <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = dist_reg;
    assign saturated = sat_reg;

`ifndef ASSERT_OFF
    // A finished root leaves a remainder no larger than twice the root
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_HOLD) |-> (rem_reg <= REM_W'({root_reg, 1'b0})))
        else $error("square root remainder out of range");
`endif

endmodule

`default_nettype wire

// ----- tb/euclidean_distance_engine_tb.sv -----
// Self-checking testbench for euclidean_distance_engine: directed, full-scale and random
// vectors under several idle/stall mixes and one long output hold-off.
// Depends on ede_pkg and the euclidean_distance_engine RTL only.
`timescale 1ns / 1ps

module euclidean_distance_engine_tb;

    import ede_pkg::*;

    localparam int FW = DEFAULT_FEATURE_WIDTH;
    localparam int SW = DEFAULT_SUM_WIDTH;
    localparam int DW = DIST_WIDTH;

    // Clamp value of the running sum of squares
    localparam logic [SW:0] SUM_MAX = {1'b0, {SW{1'b1}}};

    localparam logic signed [FW-1:0] FEAT_MAX = {1'b0, {(FW-1){1'b1}}};
    localparam logic signed [FW-1:0] FEAT_MIN = {1'b1, {(FW-1){1'b0}}};

    // Drain time after the last expected result: pipeline, queue and root unit
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 1000000;

    // One predicted output transfer
    typedef struct packed {
        logic [DW-1:0] dist_val;
        logic          sat;
    } dist_result_t;

    // Predicts distances from accepted element pairs and checks output transfers
    class DistanceScoreboard;
        logic [SW-1:0] sum_sq;
        bit            clamp_seen;
        dist_result_t  pending_q[$];
        int            errors;
        int            results_seen;

        function new();
            sum_sq       = '0;
            clamp_seen   = 1'b0;
            errors       = 0;
            results_seen = 0;
        endfunction

        // Bit-by-bit floor square root, one trial per result bit
        static function logic [DW-1:0] floor_root(logic [SW-1:0] v);
            longint unsigned trial;
            logic [DW-1:0]   root;
            root = '0;
            for (int i = DW - 1; i >= 0; i--)
            begin
                trial = longint'(root) | (64'd1 << i);
                if (trial * trial <= v)
                    root = trial[DW-1:0];
            end
            return root;
        endfunction

        // Fold one accepted pair into the sum; a last pair closes the vector
        function void note_pair(logic signed [FW-1:0] a, logic signed [FW-1:0] b,
                                logic last);
            logic signed [FW:0] d;
            logic [2*FW-1:0]    sq;
            logic [SW:0]        total;
            dist_result_t       r;
            d = a - b;
            if (d < 0)
                d = -d;
            sq    = $unsigned(d) * $unsigned(d);
            total = sum_sq + sq;
            if (total > SUM_MAX)
            begin
                sum_sq     = SUM_MAX[SW-1:0];
                clamp_seen = 1'b1;
            end
            else
                sum_sq = total[SW-1:0];
            if (last)
            begin
                r.dist_val = floor_root(sum_sq);
                r.sat      = clamp_seen;
                pending_q.insert(pending_q.size(), r);
                sum_sq     = '0;
                clamp_seen = 1'b0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH result %0d: %s", results_seen, msg);
            errors++;
        endtask

        task check_result(logic [DW-1:0] dist_in, logic sat);
            dist_result_t want;
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transfer distance=%0d saturated=%0b",
                                          dist_in, sat));
                results_seen++;
                return;
            end
            want = pending_q.pop_front();
            if (dist_in !== want.dist_val)
                report_mismatch($sformatf("distance %0d, want %0d", dist_in, want.dist_val));
            if (sat !== want.sat)
                report_mismatch($sformatf("saturated %0b, want %0b", sat, want.sat));
            results_seen++;
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [FW-1:0] feature_a;
    logic signed [FW-1:0] feature_b;
    logic                 last_element;
    logic                 out_valid;
    logic                 out_ready;
    logic [DW-1:0]        distance;
    logic                 saturated;

    DistanceScoreboard sb;

    // Idle mix, in percent per cycle; changed by the stimulus between phases
    int send_idle_pct;
    int stall_pct;
    // Length of a requested output hold-off; picked up by the receiver process
    int hold_request;
    int cycle_count;

    euclidean_distance_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .feature_a    (feature_a),
        .feature_b    (feature_b),
        .last_element (last_element),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .distance     (distance),
        .saturated    (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Output side: ready changes at the falling edge. A hold-off request keeps
    // ready low for that many cycles so the accumulator and queue back up.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Output transfers are checked at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(distance, saturated);
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one element pair and hold it until the transfer. Called at a
    // falling edge and returns at one. Idle cycles before the offer are drawn
    // per cycle, so valid only drops when an idle cycle is drawn.
    task automatic send_pair(input logic signed [FW-1:0] a, input logic signed [FW-1:0] b,
                             input logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        feature_a    = a;
        feature_b    = b;
        last_element = last;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pair(a, b, last);
        @(negedge clk);
    endtask

    // Features lean on the extremes and on small values; the rest is
    // uniform over all 16 bits.
    function automatic logic signed [FW-1:0] pick_feature();
        case ($urandom_range(9))
            0:       return FEAT_MIN;
            1:       return FEAT_MAX;
            2, 3:    return FW'(int'($urandom_range(511)) - 256);
            default: return FW'($urandom);
        endcase
    endfunction

    // Whole vectors with random lengths, mostly short so the root unit
    // becomes the bottleneck now and then
    task automatic run_vectors(input int n_items, input bit short_only);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if (short_only)
                len = $urandom_range(1, 2);
            else
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
                    6, 7, 8:          len = $urandom_range(5, 16);
                    default:          len = $urandom_range(17, 60);
                endcase
            for (int k = 0; k < len; k++)
                send_pair(pick_feature(), pick_feature(), k == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        sb            = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 0;
        cycle_count   = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        feature_a     = '0;
        feature_b     = '0;
        last_element  = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Single-pair vector straight out of reset
        send_pair('0, '0, 1'b1);
        // Largest difference both ways, and equal minimums
        send_pair(FEAT_MAX, FEAT_MIN, 1'b1);
        send_pair(FEAT_MIN, FEAT_MAX, 1'b1);
        send_pair(FEAT_MIN, FEAT_MIN, 1'b1);
        // Short vector of small and sign-crossing differences
        send_pair(FEAT_MAX, FEAT_MAX, 1'b0);
        send_pair(FW'(-1), FW'(0), 1'b0);
        send_pair(FW'(0), FW'(-1), 1'b0);
        send_pair(FW'(1), FW'(0), 1'b0);
        send_pair(FW'(256), FW'(-256), 1'b1);
        // Alternating bit patterns on both features
        send_pair(16'sh5555, 16'shAAAA, 1'b0);
        send_pair(16'shAAAA, 16'sh5555, 1'b1);
        send_pair(FEAT_MIN, FW'(0), 1'b0);
        send_pair(FW'(0), FEAT_MAX, 1'b1);
        send_pair(FW'(128), FW'(-128), 1'b1);
        send_pair(FW'(-1), FW'(-1), 1'b1);

        // Short full-scale vector, then one clean vector after it
        for (int n = 0; n < 8; n++)
            send_pair(FEAT_MAX, FEAT_MIN, n == 7);
        send_pair(FW'(3), FW'(-2), 1'b1);

        // Random vectors under each idle/stall mix
        run_vectors(420, 1'b0);
        send_idle_pct = 54;
        run_vectors(420, 1'b0);
        send_idle_pct = 0;
        stall_pct     = 54;
        run_vectors(420, 1'b0);
        send_idle_pct = 14;
        stall_pct     = 14;
        run_vectors(420, 1'b0);

        // Long output hold-off with a steady stream of short vectors behind it
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 400;
        run_vectors(80, 1'b1);
        in_valid = 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ede_pkg.sv
rtl/ede_front.sv
rtl/ede_queue.sv
rtl/ede_sqrt.sv
rtl/euclidean_distance_engine.sv
tb/euclidean_distance_engine_tb.sv
